>>> hw/rtl/lfu_pkg.sv
package lfu_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int COUNT_W = 32;
   localparam int TIME_W  = 48;
   localparam int CAP_W   = 5;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic OPC_GET = 1'b0;
   localparam logic OPC_PUT = 1'b1;

   // paddr[2] selects the register word
   localparam logic CSR_CAPACITY_SEL = 1'b0;

   // search item handed from cell to cell
   typedef struct packed {
      logic               hit;
      logic [VAL_W-1:0]   hit_value;
      logic               victim_valid;
      logic [KEY_W-1:0]   victim_key;
      logic [COUNT_W-1:0] victim_count;
      logic [TIME_W-1:0]  victim_time;
      logic               free_valid;
   } lfu_token_type;

   localparam lfu_token_type TOKEN_EMPTY = '{
      hit:          1'b0,
      hit_value:    '0,
      victim_valid: 1'b0,
      victim_key:   '0,
      victim_count: '0,
      victim_time:  '0,
      free_valid:   1'b0
   };

   // per-cell update command
   typedef struct packed {
      logic touch;
      logic set_value;
      logic clear;
      logic insert;
   } lfu_cmd_type;

endpackage

>>> hw/rtl/lfu_cache_table_unit.sv
// The search item walks the row of entry cells one cell per cycle, then the
// decide state picks hit, victim or free entry and updates the cells; the result
// and its strobe are registered from the decide state. The unit is busy from
// accepting an item until the decide state ends and accepts no new item meanwhile.
// Reset clears all entry valid bits, occupancy and time; capacity resets to 16.
// Results are strobed for one cycle; the receiver cannot stall.
module lfu_cache_table_unit import lfu_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_opcode,
   input  logic signed [KEY_W-1:0] req_lookup_key,
   input  logic signed [VAL_W-1:0] req_put_value,
   output logic                    rsp_strobe,
   output logic                    rsp_hit,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic                    rsp_evicted,
   output logic signed [KEY_W-1:0] rsp_evicted_key,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_W-1:0]       paddr,
   input  logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_W  = $clog2(CAPACITY + 1);
   localparam int WIDE_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SWEEP  = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [CAP_W-1:0]  cap_ff;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [TIME_W-1:0] time_ff, time_in;

   logic              req_opcode_ff;
   logic [KEY_W-1:0]  req_key_ff;
   logic [VAL_W-1:0]  req_value_ff;

   logic              rsp_strobe_ff;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic              rsp_evicted_ff, rsp_evicted_in;
   logic [KEY_W-1:0]  rsp_evkey_ff, rsp_evkey_in;

   lfu_token_type     tok_chain        [CAPACITY+1];
   logic [IDX_W-1:0]  hit_idx_chain    [CAPACITY+1];
   logic [IDX_W-1:0]  victim_idx_chain [CAPACITY+1];
   logic [IDX_W-1:0]  free_idx_chain   [CAPACITY+1];
   lfu_cmd_type       cmd              [CAPACITY];
   logic [CAPACITY-1:0] valid_vec;

   lfu_token_type     tok_last;
   logic [WIDE_W-1:0] cap_wide, cap_lim;
   logic              accept;
   logic              csr_write;
   logic              do_touch, do_set_value, do_evict, do_insert;
   logic [IDX_W-1:0]  ins_idx;
   logic [TIME_W-1:0] time_next;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_write && (paddr[2] == CSR_CAPACITY_SEL)) begin
         cap_ff <= pwdata[CAP_W-1:0];
      end
   end

   assign prdata = (paddr[2] == CSR_CAPACITY_SEL) ? DATA_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (accept) begin
         req_opcode_ff <= req_opcode;
         req_key_ff    <= req_lookup_key;
         req_value_ff  <= req_put_value;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SWEEP;
               cnt_in   = '0;
            end
         end
         ST_SWEEP: begin
            if (cnt_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = ST_DECIDE;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // row of entry cells
   assign tok_chain[0]        = TOKEN_EMPTY;
   assign hit_idx_chain[0]    = '0;
   assign victim_idx_chain[0] = '0;
   assign free_idx_chain[0]   = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      lfu_cell #(
         .IDX_W (IDX_W),
         .IDX   (i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .req_key        (req_key_ff),
         .tok_in         (tok_chain[i]),
         .hit_idx_in     (hit_idx_chain[i]),
         .victim_idx_in  (victim_idx_chain[i]),
         .free_idx_in    (free_idx_chain[i]),
         .tok_out        (tok_chain[i+1]),
         .hit_idx_out    (hit_idx_chain[i+1]),
         .victim_idx_out (victim_idx_chain[i+1]),
         .free_idx_out   (free_idx_chain[i+1]),
         .cmd            (cmd[i]),
         .wr_key         (req_key_ff),
         .wr_value       (req_value_ff),
         .wr_time        (time_next),
         .entry_valid    (valid_vec[i])
      );
   end

   assign tok_last  = tok_chain[CAPACITY];
   assign time_next = time_ff + TIME_W'(1);
   assign cap_wide  = WIDE_W'(cap_ff);
   assign cap_lim   = (cap_wide > WIDE_W'(CAPACITY)) ? WIDE_W'(CAPACITY) : cap_wide;

   always_comb begin
      time_in        = time_ff;
      occ_in         = occ_ff;
      rsp_hit_in     = 1'b0;
      rsp_value_in   = (req_opcode_ff == OPC_PUT) ? '0 : '1;
      rsp_evicted_in = 1'b0;
      rsp_evkey_in   = '0;
      do_touch       = 1'b0;
      do_set_value   = 1'b0;
      do_evict       = 1'b0;
      do_insert      = 1'b0;
      ins_idx        = free_idx_chain[CAPACITY];
      if ((state_ff == ST_DECIDE) && (cap_lim != '0)) begin
         time_in = time_next;
         if (tok_last.hit) begin
            rsp_hit_in = 1'b1;
            do_touch   = 1'b1;
            if (req_opcode_ff == OPC_PUT) begin
               do_set_value = 1'b1;
            end else begin
               rsp_value_in = tok_last.hit_value;
            end
         end else if (req_opcode_ff == OPC_PUT) begin
            do_evict = (WIDE_W'(occ_ff) >= cap_lim) && tok_last.victim_valid;
            if (do_evict) begin
               rsp_evicted_in = 1'b1;
               rsp_evkey_in   = tok_last.victim_key;
               if (!tok_last.free_valid ||
                   (victim_idx_chain[CAPACITY] < free_idx_chain[CAPACITY])) begin
                  ins_idx = victim_idx_chain[CAPACITY];
               end
            end
            do_insert = do_evict || tok_last.free_valid;
            occ_in    = occ_ff - OCC_W'(do_evict) + OCC_W'(do_insert);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cmd[i].touch     = do_touch     && (hit_idx_chain[CAPACITY] == IDX_W'(i));
         cmd[i].set_value = do_set_value && (hit_idx_chain[CAPACITY] == IDX_W'(i));
         cmd[i].clear     = do_evict     && (victim_idx_chain[CAPACITY] == IDX_W'(i));
         cmd[i].insert    = do_insert    && (ins_idx == IDX_W'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff        <= '0;
         time_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         occ_ff        <= occ_in;
         time_ff       <= time_in;
         rsp_strobe_ff <= (state_ff == ST_DECIDE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         rsp_hit_ff     <= rsp_hit_in;
         rsp_value_ff   <= rsp_value_in;
         rsp_evicted_ff <= rsp_evicted_in;
         rsp_evkey_ff   <= rsp_evkey_in;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evkey_ff;

   a_decide_strobes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |=> rsp_strobe_ff)
      else $error("decide cycle without result strobe");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe longer than one cycle");

   a_occ_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(occ_ff))
      else $error("occupancy out of step with entry valid bits");

   a_evict_not_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_evicted_ff) |-> !rsp_hit_ff)
      else $error("eviction reported on a hit");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after accepting an item");

endmodule

>>> hw/rtl/lfu_cell.sv
module lfu_cell import lfu_pkg::*; #(
   parameter int IDX_W = 4,
   parameter int IDX   = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [KEY_W-1:0]    req_key,
   input  lfu_token_type       tok_in,
   input  logic [IDX_W-1:0]    hit_idx_in,
   input  logic [IDX_W-1:0]    victim_idx_in,
   input  logic [IDX_W-1:0]    free_idx_in,
   output lfu_token_type       tok_out,
   output logic [IDX_W-1:0]    hit_idx_out,
   output logic [IDX_W-1:0]    victim_idx_out,
   output logic [IDX_W-1:0]    free_idx_out,
   input  lfu_cmd_type         cmd,
   input  logic [KEY_W-1:0]    wr_key,
   input  logic [VAL_W-1:0]    wr_value,
   input  logic [TIME_W-1:0]   wr_time,
   output logic                entry_valid
);

   logic               valid_ff, valid_in;
   logic [KEY_W-1:0]   key_ff;
   logic [VAL_W-1:0]   value_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [TIME_W-1:0]  time_ff;

   lfu_token_type      tok_ff, tok_in_next;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in_next;
   logic [IDX_W-1:0]   victim_idx_ff, victim_idx_in_next;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in_next;

   logic own_hit;
   logic own_older;

   assign own_hit   = valid_ff && (key_ff == req_key);
   assign own_older = {count_ff, time_ff} < {tok_in.victim_count, tok_in.victim_time};

   always_comb begin
      tok_in_next        = tok_in;
      hit_idx_in_next    = hit_idx_in;
      victim_idx_in_next = victim_idx_in;
      free_idx_in_next   = free_idx_in;
      if (!tok_in.hit && own_hit) begin
         tok_in_next.hit       = 1'b1;
         tok_in_next.hit_value = value_ff;
         hit_idx_in_next       = IDX_W'(IDX);
      end
      // strict compare: earlier cell wins a full tie
      if (valid_ff && (!tok_in.victim_valid || own_older)) begin
         tok_in_next.victim_valid = 1'b1;
         tok_in_next.victim_key   = key_ff;
         tok_in_next.victim_count = count_ff;
         tok_in_next.victim_time  = time_ff;
         victim_idx_in_next       = IDX_W'(IDX);
      end
      if (!tok_in.free_valid && !valid_ff) begin
         tok_in_next.free_valid = 1'b1;
         free_idx_in_next       = IDX_W'(IDX);
      end
   end

   always_ff @(posedge clock) begin
      tok_ff        <= tok_in_next;
      hit_idx_ff    <= hit_idx_in_next;
      victim_idx_ff <= victim_idx_in_next;
      free_idx_ff   <= free_idx_in_next;
   end

   assign tok_out        = tok_ff;
   assign hit_idx_out    = hit_idx_ff;
   assign victim_idx_out = victim_idx_ff;
   assign free_idx_out   = free_idx_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.insert) begin
         valid_in = 1'b1;
      end else if (cmd.clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         key_ff   <= wr_key;
         value_ff <= wr_value;
         count_ff <= COUNT_W'(1);
         time_ff  <= wr_time;
      end else begin
         if (cmd.touch) begin
            if (count_ff != '1) begin
               count_ff <= count_ff + COUNT_W'(1);
            end
            time_ff <= wr_time;
         end
         if (cmd.set_value) begin
            value_ff <= wr_value;
         end
      end
   end

   assign entry_valid = valid_ff;

endmodule

>>> test/testbench.sv
module testbench;
   import lfu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS   = CAPACITY_DEFAULT;
   localparam int LATENCY = CAPACITY_DEFAULT + 2;
   localparam int POOL    = 24;

   typedef struct {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
      logic [COUNT_W-1:0] uses;
      logic [TIME_W-1:0]  stamp;
   } slot_type;

   typedef struct {
      logic             hit;
      logic [VAL_W-1:0] read_value;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
   } outcome_type;

   class lfu_table_model;
      slot_type          slots[SLOTS];
      outcome_type       outcome_q[$];
      logic [TIME_W-1:0] now_stamp;
      int                capacity;
      int                occupied;
      int                failures;

      function new();
         foreach (slots[i]) slots[i].valid = 1'b0;
         now_stamp = '0;
         capacity  = 16;
         occupied  = 0;
         failures  = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      function int outstanding();
         return outcome_q.size();
      endfunction

      function void mismatch(string what, logic [63:0] want, logic [63:0] got);
         failures++;
         if (failures <= 10)
            $display("mismatch %s: expected %h, actual %h", what, want, got);
      endfunction

      function void note_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
         outcome_type o;
         int          eff;
         int          found;
         int          victim;
         bit          placed;
         o.hit         = 1'b0;
         o.read_value  = (op == OPC_PUT) ? '0 : '1;
         o.evicted     = 1'b0;
         o.evicted_key = '0;
         eff = (capacity > SLOTS) ? SLOTS : capacity;
         if (eff != 0) begin
            now_stamp = now_stamp + 1'b1;
            found = -1;
            for (int i = 0; i < SLOTS; i++)
               if (found < 0 && slots[i].valid && slots[i].key == key) found = i;
            if (found >= 0) begin
               o.hit = 1'b1;
               if (slots[found].uses != '1) slots[found].uses++;
               slots[found].stamp = now_stamp;
               if (op == OPC_PUT) slots[found].value = val;
               else o.read_value = slots[found].value;
            end else if (op == OPC_PUT) begin
               if (occupied >= eff) begin
                  victim = -1;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (slots[i].valid && (victim < 0 ||
                         slots[i].uses < slots[victim].uses ||
                         (slots[i].uses == slots[victim].uses &&
                          slots[i].stamp < slots[victim].stamp)))
                        victim = i;
                  end
                  if (victim >= 0) begin
                     slots[victim].valid = 1'b0;
                     o.evicted     = 1'b1;
                     o.evicted_key = slots[victim].key;
                     if (occupied > 0) occupied--;
                  end
               end
               placed = 1'b0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!placed && !slots[i].valid) begin
                     slots[i] = '{1'b1, key, val, 1, now_stamp};
                     occupied++;
                     placed = 1'b1;
                  end
               end
            end
         end
         outcome_q.push_back(o);
      endfunction

      function void check_response(logic hit, logic [VAL_W-1:0] rv, logic ev,
                                   logic [KEY_W-1:0] ek);
         outcome_type o;
         if (outcome_q.size() == 0) begin
            mismatch("unexpected result", 64'd0, 64'd1);
            return;
         end
         o = outcome_q.pop_front();
         if (hit !== o.hit) mismatch("hit", 64'(o.hit), 64'(hit));
         if (rv !== o.read_value) mismatch("read_value", 64'(o.read_value), 64'(rv));
         if (ev !== o.evicted) mismatch("evicted", 64'(o.evicted), 64'(ev));
         if (ek !== o.evicted_key) mismatch("evicted_key", 64'(o.evicted_key), 64'(ek));
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_opcode = OPC_GET;
   logic signed [KEY_W-1:0] req_lookup_key = '0;
   logic signed [VAL_W-1:0] req_put_value = '0;
   logic                    rsp_strobe;
   logic                    rsp_hit;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic                    rsp_evicted;
   logic signed [KEY_W-1:0] rsp_evicted_key;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [ADDR_W-1:0]       paddr = '0;
   logic [DATA_W-1:0]       pwdata = '0;
   logic [DATA_W-1:0]       prdata;
   logic                    pready;

   lfu_table_model table_model;
   int             idle_pct = 0;

   lfu_cache_table_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_lookup_key(req_lookup_key),
      .req_put_value(req_put_value),
      .rsp_strobe(rsp_strobe), .rsp_hit(rsp_hit), .rsp_read_value(rsp_read_value),
      .rsp_evicted(rsp_evicted), .rsp_evicted_key(rsp_evicted_key),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            table_model.check_response(rsp_hit, rsp_read_value, rsp_evicted,
                                       rsp_evicted_key);
         if (start && !busy)
            table_model.note_request(req_opcode, req_lookup_key, req_put_value);
      end
   end

   task automatic issue(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
      start          <= 1'b1;
      req_opcode     <= op;
      req_lookup_key <= key;
      req_put_value  <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(40, 1)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (table_model.outstanding() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // write then read back, only once the table is quiet
   task automatic program_capacity(logic [CAP_W-1:0] cap);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_CAPACITY_SEL, 2'b00};
      pwdata  <= DATA_W'(cap);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      table_model.set_capacity(cap);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== DATA_W'(cap)) table_model.mismatch("capacity readback",
                                                        64'(cap), 64'(prdata));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int               cap_plan[8];
      int               idle_plan[4];
      logic [KEY_W-1:0] key_pool[POOL];
      logic [KEY_W-1:0] key;
      logic             op;
      table_model = new();
      cap_plan  = '{16, 1, 31, 0, 3, 16, 8, 17};
      idle_plan = '{0, 53, 0, 20};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, update, lowered capacity, disabled, saturated
      issue(OPC_GET, 32'h0000_0000, 32'h1234_5678);
      issue(OPC_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      issue(OPC_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      issue(OPC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
      issue(OPC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(OPC_PUT, 32'h0000_0000, 32'h0000_0000);
      issue(OPC_PUT, 32'h8000_0000, 32'h5555_AAAA);
      issue(OPC_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      issue(OPC_GET, 32'h0000_0000, 32'h0000_0000);
      program_capacity(5'd2);
      issue(OPC_PUT, 32'h0000_0005, 32'hAAAA_5555);
      issue(OPC_PUT, 32'h0000_0006, 32'h0000_0001);
      issue(OPC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      issue(OPC_GET, 32'h0000_0005, 32'h0000_0000);
      program_capacity(5'd0);
      issue(OPC_GET, 32'h8000_0000, 32'h0000_0000);
      issue(OPC_PUT, 32'h0000_0009, 32'h0000_0009);
      program_capacity(5'd31);
      issue(OPC_PUT, 32'h0000_0009, 32'h0000_0009);
      issue(OPC_GET, 32'h0000_0009, 32'h0000_0000);

      for (int ph = 0; ph < 8; ph++) begin
         idle_pct = idle_plan[ph % 4];
         program_capacity(CAP_W'(ph == 7 ? $urandom_range(31) : cap_plan[ph]));
         foreach (key_pool[i]) key_pool[i] = $urandom;
         for (int n = 0; n < 85; n++) begin
            op = $urandom_range(1) ? OPC_PUT : OPC_GET;
            // skewed choice so use counts spread apart
            if ($urandom_range(99) < 85)
               key = key_pool[$urandom_range(0, $urandom_range(POOL - 1))];
            else
               key = $urandom;
            issue(op, key, $urandom);
         end
      end

      drain();
      if (table_model.failures == 0 && table_model.outstanding() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

>>> files.f
hw/rtl/lfu_pkg.sv
hw/rtl/lfu_cell.sv
hw/rtl/lfu_cache_table_unit.sv
test/testbench.sv
